@@ design/lpsi_pkg.sv @@
// shared types and constants for the line prefix/suffix inserter
package lpsi_pkg;

	localparam int TOKEN_MAX_BYTES_DEF = 8;
	localparam int LEN_W = 4;
	localparam int TEXT_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	localparam logic [1:0] ST_FIRST = 2'd0;
	localparam logic [1:0] ST_MID = 2'd1;
	localparam logic [1:0] ST_CR = 2'd2;
	localparam logic [1:0] ST_LF = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_TEXT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_TEXT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUFFIX_LENGTH = 3'd4;

	typedef struct packed {
		logic [7:0] ch;
		logic pre;
		logic post;
	} entry_t;

	typedef struct packed {
		logic [TEXT_W-1:0] prefix_text;
		logic [LEN_W-1:0] prefix_length;
		logic [TEXT_W-1:0] suffix_text;
		logic [LEN_W-1:0] suffix_length;
	} tokens_t;

endpackage

@@ design/line_prefix_suffix_inserter_top.sv @@
// top level of the line prefix/suffix inserter
//
//   channel   direction   handshake            payload
//   in        sink        in_valid/in_stall    in_byte
//   out       source      out_valid/out_stall  out_byte, last
//   cfg       sink        cfg_we               cfg_index, cfg_data
//
// back end: one byte per cycle unless queue empty or stalled; prefix, suffix, then the byte
// a two-entry queue holds classified items; input stalls while it is full (tokens or out_stall)
// output register sits after the back end, so out_valid, out_byte and last are registered
// reset clears line state, queue, output valid and all configuration registers
module line_prefix_suffix_inserter_top #(
	parameter int TOKEN_MAX_BYTES = lpsi_pkg::TOKEN_MAX_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last,
	input logic cfg_we,
	input logic [lpsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lpsi_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic output_enable_q;
	lpsi_pkg::tokens_t tokens_q;
	logic push;
	lpsi_pkg::entry_t push_entry;
	logic queue_full;
	logic queue_empty;
	logic pop;
	lpsi_pkg::entry_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_enable_q <= 1'b0;
			tokens_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpsi_pkg::REG_OUTPUT_ENABLE: output_enable_q <= cfg_data[0];
				lpsi_pkg::REG_PREFIX_TEXT: tokens_q.prefix_text <= cfg_data;
				lpsi_pkg::REG_PREFIX_LENGTH:
					tokens_q.prefix_length <= cfg_data[lpsi_pkg::LEN_W-1:0];
				lpsi_pkg::REG_SUFFIX_TEXT: tokens_q.suffix_text <= cfg_data;
				lpsi_pkg::REG_SUFFIX_LENGTH:
					tokens_q.suffix_length <= cfg_data[lpsi_pkg::LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lpsi_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.output_enable(output_enable_q),
		.push(push),
		.push_entry(push_entry),
		.queue_full(queue_full)
	);

	lpsi_queue #(
		.DEPTH(lpsi_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.full(queue_full),
		.pop(pop),
		.empty(queue_empty),
		.head(head)
	);

	lpsi_back #(
		.TOKEN_MAX_BYTES(TOKEN_MAX_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(queue_empty),
		.head(head),
		.pop(pop),
		.tokens(tokens_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

endmodule

@@ design/lpsi_front.sv @@
// front end: tracks line state and classifies each incoming byte
module lpsi_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] in_byte,
	input logic output_enable,
	output logic push,
	output lpsi_pkg::entry_t push_entry,
	input logic queue_full
);

	logic [1:0] line_state_q;
	logic [1:0] next_state;
	logic pre;
	logic post;
	logic accept;

	assign in_stall = queue_full;
	assign accept = in_valid && !queue_full;

	always_comb begin
		if (in_byte == lpsi_pkg::CH_CR) begin
			pre = (line_state_q != lpsi_pkg::ST_MID);
			post = 1'b1;
			next_state = lpsi_pkg::ST_CR;
		end else if (in_byte == lpsi_pkg::CH_LF) begin
			pre = (line_state_q == lpsi_pkg::ST_FIRST) || (line_state_q == lpsi_pkg::ST_LF);
			post = (line_state_q != lpsi_pkg::ST_CR);
			next_state = lpsi_pkg::ST_LF;
		end else begin
			pre = (line_state_q != lpsi_pkg::ST_MID);
			post = 1'b0;
			next_state = lpsi_pkg::ST_MID;
		end
	end

	assign push = accept && output_enable;
	assign push_entry = '{ch: in_byte, pre: pre, post: post};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_state_q <= lpsi_pkg::ST_FIRST;
		end else if (accept) begin
			line_state_q <= next_state;
		end
	end

endmodule

@@ design/lpsi_queue.sv @@
// short register queue between front and back
module lpsi_queue #(
	parameter int DEPTH = lpsi_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lpsi_pkg::entry_t push_entry,
	output logic full,
	input logic pop,
	output logic empty,
	output lpsi_pkg::entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lpsi_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/lpsi_back.sv @@
// back end: emits the flagged prefix and suffix, then the byte, of each queued entry
module lpsi_back #(
	parameter int TOKEN_MAX_BYTES = lpsi_pkg::TOKEN_MAX_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input lpsi_pkg::entry_t head,
	output logic pop,
	input lpsi_pkg::tokens_t tokens,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] out_byte,
	output logic last
);

	localparam int IDX_W = (TOKEN_MAX_BYTES > 1) ? $clog2(TOKEN_MAX_BYTES) : 1;
	localparam logic [1:0] PH_PRE = 2'd0;
	localparam logic [1:0] PH_SUF = 2'd1;
	localparam logic [1:0] PH_CHR = 2'd2;
	localparam logic [lpsi_pkg::LEN_W-1:0] MAX_LEN = lpsi_pkg::LEN_W'(TOKEN_MAX_BYTES);

	logic [1:0] phase_q;
	logic [IDX_W-1:0] idx_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic last_q;

	logic [lpsi_pkg::LEN_W-1:0] plen;
	logic [lpsi_pkg::LEN_W-1:0] slen;
	logic pre_act;
	logic suf_act;
	logic [1:0] eff_phase;
	logic [IDX_W-1:0] eff_idx;
	logic [lpsi_pkg::LEN_W-1:0] eff_idx_ext;
	logic fire;
	logic [7:0] emit_byte;
	logic tok_end;

	assign plen = (tokens.prefix_length > MAX_LEN) ? MAX_LEN : tokens.prefix_length;
	assign slen = (tokens.suffix_length > MAX_LEN) ? MAX_LEN : tokens.suffix_length;
	assign pre_act = head.pre && (plen != '0);
	assign suf_act = head.post && (slen != '0);

	always_comb begin
		if (phase_q == PH_PRE && pre_act) begin
			eff_phase = PH_PRE;
		end else if (phase_q != PH_CHR && suf_act) begin
			eff_phase = PH_SUF;
		end else begin
			eff_phase = PH_CHR;
		end
	end

	assign eff_idx = (eff_phase == phase_q) ? idx_q : '0;
	assign eff_idx_ext = lpsi_pkg::LEN_W'(eff_idx);

	always_comb begin
		unique case (eff_phase)
			PH_PRE: begin
				emit_byte = tokens.prefix_text[{eff_idx, 3'b000} +: 8];
				tok_end = (eff_idx_ext == plen - 1'b1);
			end
			PH_SUF: begin
				emit_byte = tokens.suffix_text[{eff_idx, 3'b000} +: 8];
				tok_end = (eff_idx_ext == slen - 1'b1);
			end
			default: begin
				emit_byte = head.ch;
				tok_end = 1'b1;
			end
		endcase
	end

	assign fire = !empty && (!out_valid_q || !out_stall);
	assign pop = fire && (eff_phase == PH_CHR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				if (eff_phase == PH_CHR) begin
					phase_q <= PH_PRE;
					idx_q <= '0;
				end else if (tok_end) begin
					phase_q <= (eff_phase == PH_PRE) ? PH_SUF : PH_CHR;
					idx_q <= '0;
				end else begin
					phase_q <= eff_phase;
					idx_q <= eff_idx + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= emit_byte;
			last_q <= (eff_phase == PH_CHR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign last = last_q;

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the line prefix/suffix inserter
`timescale 1ns / 1ps

module tb;

	localparam int TOKEN_MAX = lpsi_pkg::TOKEN_MAX_BYTES_DEF;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [7:0] ch;
		logic is_last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic last;
	logic cfg_we = 1'b0;
	logic [lpsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lpsi_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// register shadows and line state of the predictor
	logic oe_q = 1'b0;
	logic [lpsi_pkg::TEXT_W-1:0] prefix_text_q = '0;
	logic [lpsi_pkg::LEN_W-1:0] prefix_len_q = '0;
	logic [lpsi_pkg::TEXT_W-1:0] suffix_text_q = '0;
	logic [lpsi_pkg::LEN_W-1:0] suffix_len_q = '0;
	logic [1:0] line_st = lpsi_pkg::ST_FIRST;

	logic [7:0] pending_bytes [$];
	out_beat_t expected_beats [$];
	out_beat_t want;
	int items_queued = 0;
	int fail_count = 0;
	int tx_wait = 0;
	int rx_wait = 0;
	bit tx_idle_en = 1'b0;
	bit rx_idle_en = 1'b0;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;

	line_prefix_suffix_inserter_top dut (.*);

	always #1 clk = ~clk;

	function automatic void push_token(logic [lpsi_pkg::TEXT_W-1:0] text,
			logic [lpsi_pkg::LEN_W-1:0] len);
		int n;
		n = (int'(len) > TOKEN_MAX) ? TOKEN_MAX : int'(len);
		for (int k = 0; k < n; k++)
			expected_beats.push_back({text[k*8 +: 8], 1'b0});
	endfunction

	function automatic void predict_wrap(logic [7:0] c);
		logic pre;
		logic post;
		logic [1:0] nxt;
		if (c == lpsi_pkg::CH_CR) begin
			pre = (line_st != lpsi_pkg::ST_MID);
			post = 1'b1;
			nxt = lpsi_pkg::ST_CR;
		end else if (c == lpsi_pkg::CH_LF) begin
			pre = (line_st == lpsi_pkg::ST_FIRST || line_st == lpsi_pkg::ST_LF);
			post = (line_st != lpsi_pkg::ST_CR);
			nxt = lpsi_pkg::ST_LF;
		end else begin
			pre = (line_st != lpsi_pkg::ST_MID);
			post = 1'b0;
			nxt = lpsi_pkg::ST_MID;
		end
		line_st = nxt;
		if (oe_q) begin
			if (pre)
				push_token(prefix_text_q, prefix_len_q);
			if (post)
				push_token(suffix_text_q, suffix_len_q);
			expected_beats.push_back({c, 1'b1});
		end
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			tx_wait = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_wrap(in_byte);
				tx_wait = tx_idle_en ? $urandom_range(0, 14) : 0;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_wait > 0 || pending_bytes.size() == 0) begin
					if (tx_wait > 0)
						tx_wait--;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_byte <= pending_bytes.pop_front();
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_served != hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual byte %h last %b",
						$time, out_byte, last);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (out_byte !== want.ch) begin
						$display("%0t: out_byte mismatch, expected %h actual %h",
							$time, want.ch, out_byte);
						fail_count++;
					end
					if (last !== want.is_last) begin
						$display("%0t: last mismatch, expected %b actual %b",
							$time, want.is_last, last);
						fail_count++;
					end
				end
				rx_wait = rx_idle_en ? $urandom_range(0, 14) : 0;
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			out_stall <= (rx_wait > 0) || (hold_left != 0);
		end
	end

	task automatic set_reg(input logic [lpsi_pkg::CFG_IDX_W-1:0] idx,
			input logic [lpsi_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			lpsi_pkg::REG_OUTPUT_ENABLE: oe_q = data[0];
			lpsi_pkg::REG_PREFIX_TEXT: prefix_text_q = data[lpsi_pkg::TEXT_W-1:0];
			lpsi_pkg::REG_PREFIX_LENGTH: prefix_len_q = data[lpsi_pkg::LEN_W-1:0];
			lpsi_pkg::REG_SUFFIX_TEXT: suffix_text_q = data[lpsi_pkg::TEXT_W-1:0];
			lpsi_pkg::REG_SUFFIX_LENGTH: suffix_len_q = data[lpsi_pkg::LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [lpsi_pkg::CFG_DATA_W-1:0] en,
			input logic [lpsi_pkg::CFG_DATA_W-1:0] pt,
			input logic [lpsi_pkg::CFG_DATA_W-1:0] pl,
			input logic [lpsi_pkg::CFG_DATA_W-1:0] st,
			input logic [lpsi_pkg::CFG_DATA_W-1:0] sl);
		set_reg(lpsi_pkg::REG_OUTPUT_ENABLE, en);
		set_reg(lpsi_pkg::REG_PREFIX_TEXT, pt);
		set_reg(lpsi_pkg::REG_PREFIX_LENGTH, pl);
		set_reg(lpsi_pkg::REG_SUFFIX_TEXT, st);
		set_reg(lpsi_pkg::REG_SUFFIX_LENGTH, sl);
	endtask

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		items_queued++;
	endtask

	// mostly well-formed lines with random text, some noise
	task automatic queue_line();
		int n;
		logic [7:0] b;
		if ($urandom_range(0, 9) < 2) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				case ($urandom_range(0, 2))
					0: b = lpsi_pkg::CH_CR;
					1: b = lpsi_pkg::CH_LF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				push_byte(b);
			end
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) begin
				do b = 8'($urandom_range(0, 255));
				while (b == lpsi_pkg::CH_CR || b == lpsi_pkg::CH_LF);
				push_byte(b);
			end
			case ($urandom_range(0, 3))
				0: push_byte(lpsi_pkg::CH_CR);
				1: push_byte(lpsi_pkg::CH_LF);
				2: begin
					push_byte(lpsi_pkg::CH_CR);
					push_byte(lpsi_pkg::CH_LF);
				end
				default: ;
			endcase
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int n_items, input bit tx_idle, input bit rx_idle,
			input bit hold);
		int target;
		@(negedge clk);
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		if (hold)
			hold_req++;
		target = items_queued + n_items;
		while (items_queued < target)
			queue_line();
		settle();
	endtask

	initial begin
		logic [7:0] directed_seq [16];
		directed_seq = '{lpsi_pkg::CH_LF, lpsi_pkg::CH_LF, 8'h41, 8'h00, 8'hFF,
			lpsi_pkg::CH_CR, lpsi_pkg::CH_CR, lpsi_pkg::CH_LF, lpsi_pkg::CH_CR, 8'h62,
			lpsi_pkg::CH_LF, 8'h55, 8'hAA, lpsi_pkg::CH_CR, lpsi_pkg::CH_LF,
			lpsi_pkg::CH_LF};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		configure(64'd1, '1, 64'd8, '0, 64'd8);
		// writes beyond the register map must be ignored
		for (int i = int'(lpsi_pkg::REG_SUFFIX_LENGTH) + 1; i < (1 << lpsi_pkg::CFG_IDX_W);
				i++)
			set_reg(lpsi_pkg::CFG_IDX_W'(i), '0);

		// every line state and byte kind, starting from the first character
		@(negedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		foreach (directed_seq[i])
			push_byte(directed_seq[i]);
		settle();

		configure(64'd1, {$urandom, $urandom}, 64'd8, {$urandom, $urandom}, 64'd8);
		run_phase(50, 1'b1, 1'b1, 1'b0);
		run_phase(50, 1'b0, 1'b0, 1'b1);

		configure(64'd1, {$urandom, $urandom}, '0, {$urandom, $urandom}, '0);
		run_phase(40, 1'b1, 1'b0, 1'b0);

		// output disabled: state advances silently
		configure({$urandom, $urandom} & ~64'h1, {$urandom, $urandom},
			64'($urandom_range(0, 15)), {$urandom, $urandom}, 64'($urandom_range(0, 15)));
		run_phase(40, 1'b0, 1'b1, 1'b0);

		// oversized lengths saturate, zero bytes inside tokens
		configure(64'd1, 64'h00FF_0000_FF00_00FF, 64'd15, 64'h0000_00FF_0000_0000, 64'd9);
		run_phase(50, 1'b0, 1'b1, 1'b0);

		for (int p = 0; p < 3; p++) begin
			configure(64'd1, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			run_phase(25, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), p == 0);
		end

		if (fail_count == 0)
			$display("line_prefix_suffix_inserter_top test passed");
		else
			$display("line_prefix_suffix_inserter_top test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("line_prefix_suffix_inserter_top test failed");
		$finish;
	end

endmodule
